// File: hw/rtl/mmnorm_pkg.sv
// ----------------------------------------------------------------------------
// mmnorm_pkg
// types and constants shared by the min-max normalizer and its divider
// ----------------------------------------------------------------------------
package mmnorm_pkg;

  // command codes
  localparam logic [1:0] FUNC_CLEAR     = 2'd0;
  localparam logic [1:0] FUNC_OBSERVE   = 2'd1;
  localparam logic [1:0] FUNC_NORMALIZE = 2'd2;

  // fixed point
  localparam int unsigned QBITS = 16;               // quotient bits, Q0.16
  localparam int unsigned CNT_W = 5;                // holds QBITS
  localparam logic [16:0] ONE_Q16 = 17'h10000;      // 1.0 in Q1.16

  typedef struct packed {
    logic [1:0]         func;
    logic [5:0]         dim;
    logic signed [31:0] sample;
  } item_t;

  typedef struct packed {
    logic [16:0] scaled;
    logic        flat;
  } result_t;

  // one memory entry: running range of a dimension
  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } range_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DIV
  } state_t;

endpackage

// File: hw/rtl/mmnorm_div.sv
// ----------------------------------------------------------------------------
// mmnorm_div
// restoring divider, one quotient bit per cycle, (num << 16) / den with num < den
// ----------------------------------------------------------------------------
module mmnorm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [15:0] quo
);
  import mmnorm_pkg::*;

  logic [31:0]      rem;
  logic [31:0]      div;
  logic [CNT_W-1:0] cnt;
  logic             active;
  logic [32:0]      shifted;
  logic [32:0]      diff;
  logic             take;

  // remainder stays below the divisor, so the shifted value fits in 33 bits
  assign shifted = {rem, 1'b0};
  assign diff    = shifted - {1'b0, div};
  assign take    = (shifted >= {1'b0, div});

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (load) begin
        active <= 1'b1;
        cnt    <= CNT_W'(QBITS);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= num;
      div <= den;
      quo <= '0;
    end else if (active) begin
      rem <= take ? diff[31:0] : shifted[31:0];
      quo <= {quo[14:0], take};
    end
  end

endmodule

// File: hw/rtl/minmax_feature_normalizer.sv
// ----------------------------------------------------------------------------
// minmax_feature_normalizer
// per-dimension running min/max tracker and (x - min) / (max - min) scaler
// ----------------------------------------------------------------------------
// usage
//   command channel: item is taken at a rising edge with start high and busy
//   low. func selects clear (forget all dimensions), observe (fold sample
//   into the range of dim) or normalize (scale sample against that range).
//   result channel: done is high for exactly one cycle with result valid;
//   only normalize produces a result, and the receiver cannot stall it.
// flow
//   clear and the unused code leave busy low.
//   observe reads the range memory, then modifies and writes it back.
//   normalize of an unseen, flat or out-of-range dimension, or a sample
//   clamped to 0 or 1.0, skips the divider; done is registered from the look state.
//   otherwise the shared divider runs one quotient bit per cycle for all 16
//   bits, and busy stays high until the result strobe.
// reset
//   rst clears all seen flags, the controller and the done strobe; the range
//   memory keeps its contents and is rewritten on a first observation.
// ----------------------------------------------------------------------------
module minmax_feature_normalizer #(
  parameter int unsigned MAX_DIMS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mmnorm_pkg::item_t   item,
  output logic                done,
  output mmnorm_pkg::result_t result
);
  import mmnorm_pkg::*;

  localparam int unsigned AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  // range store, one entry per dimension, registered read
  range_t              mem [MAX_DIMS];
  range_t              rd;
  logic [MAX_DIMS-1:0] seen;

  state_t        state;
  state_t        state_next;
  item_t         cur;
  logic [AW-1:0] addr_q;
  logic          in_range_q;

  logic [15:0]   dim_wide;
  logic [AW-1:0] addr;
  logic          in_range;
  logic          accept;

  logic          seen_hit;
  logic          obs_wr;
  range_t        upd;
  logic [31:0]   div_num;
  logic [31:0]   div_den;
  logic          div_load;
  logic          div_done;
  logic [15:0]   div_quo;
  logic          res_fire;
  result_t       res_val;

  assign dim_wide = 16'(item.dim);
  assign addr     = dim_wide[AW-1:0];
  assign in_range = (dim_wide < 16'(MAX_DIMS));
  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;

  // capture the command and start the memory read in the same edge
  always_ff @(posedge clk) begin
    if (accept) begin
      cur        <= item;
      addr_q     <= addr;
      in_range_q <= in_range;
      rd         <= mem[addr];
    end
  end

  // observe: first sample seeds both bounds, later ones widen the range
  assign seen_hit = in_range_q && seen[addr_q];
  assign obs_wr   = (state == ST_LOOK) && (cur.func == FUNC_OBSERVE) && in_range_q;

  always_comb begin
    if (seen_hit) begin
      upd.lo = ($signed(cur.sample) < $signed(rd.lo)) ? cur.sample : rd.lo;
      upd.hi = ($signed(cur.sample) > $signed(rd.hi)) ? cur.sample : rd.hi;
    end else begin
      upd.lo = cur.sample;
      upd.hi = cur.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (obs_wr) begin
      mem[addr_q] <= upd;
    end
  end

  // seen flags in flops so clear resets every flag together
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (accept && (item.func == FUNC_CLEAR)) begin
      seen <= '0;
    end else if (obs_wr) begin
      seen[addr_q] <= 1'b1;
    end
  end

  // both differences are below 2^32 and positive on the divide path
  assign div_num = cur.sample - rd.lo;
  assign div_den = rd.hi - rd.lo;

  mmnorm_div u_div (
    .clk  (clk),
    .rst  (rst),
    .load (div_load),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    div_load       = 1'b0;
    res_fire       = 1'b0;
    res_val.scaled = '0;
    res_val.flat   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && ((item.func == FUNC_OBSERVE) || (item.func == FUNC_NORMALIZE))) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = ST_IDLE;
        if (cur.func == FUNC_NORMALIZE) begin
          res_fire = 1'b1;
          priority if (!seen_hit || (rd.lo == rd.hi)) begin
            // unseen, out of range or zero-width range
            res_val.flat = 1'b1;
          end else if ($signed(cur.sample) <= $signed(rd.lo)) begin
            res_val.scaled = '0;
          end else if ($signed(cur.sample) >= $signed(rd.hi)) begin
            res_val.scaled = ONE_Q16;
          end else begin
            res_fire   = 1'b0;
            div_load   = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_fire       = 1'b1;
          res_val.scaled = {1'b0, div_quo};
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      result <= res_val;
    end
  end

`ifndef ASSERT_OFF
  a_done_source : assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_LOOK) || ($past(state) == ST_DIV))
    else $error("result strobe without a normalize in flight");

  a_flat_zero : assert property (@(posedge clk) disable iff (rst)
    (done && result.flat) |-> (result.scaled == '0))
    else $error("flat result with nonzero scaled value");

  a_scaled_range : assert property (@(posedge clk) disable iff (rst)
    done |-> (result.scaled <= ONE_Q16))
    else $error("scaled value above 1.0");

  a_div_in_div : assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

  a_clear_all : assert property (@(posedge clk) disable iff (rst)
    (accept && (item.func == FUNC_CLEAR)) |=> (seen == '0))
    else $error("clear left a seen flag set");
`endif

endmodule

// File: dv/tb_minmax_feature_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_minmax_feature_normalizer
// self-checking bench for the min-max feature normalizer: a directed table
// covers unseen, flat, clamped and extreme ranges and the clear command, then
// random observe/normalize traffic is scored against an in-bench range tracker
// ----------------------------------------------------------------------------
module tb_minmax_feature_normalizer;
  import mmnorm_pkg::*;

  localparam int DIMS = 64;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;     // ignored by the block
  localparam int RANDOM_ITEMS = 1300;
  localparam int SETTLE_CYCLES = 24;             // covers the longest item, a divide
  localparam int IDLE_LIMIT = 3000;              // cycles with no transfer

  // one row of the directed table; typed rows carry their own answer
  typedef struct packed {
    logic [1:0]         func;
    logic [5:0]         dim;
    logic signed [31:0] sample;
    logic               typed;
    logic [16:0]        scaled;
    logic               flat;
  } dir_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  item_t   item = '0;
  logic    done;
  result_t result;

  // bench copy of the per-dimension ranges
  int range_lo [DIMS];
  int range_hi [DIMS];
  bit range_seen [DIMS];

  // normalize answers still owed by the block, oldest first
  result_t scaled_due [$];

  int mismatches = 0;
  int idle_cycles = 0;
  bit burst = 1'b0;

  minmax_feature_normalizer #(
    .MAX_DIMS(DIMS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .item  (item),
    .done  (done),
    .result(result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // directed table: extremes, every command, unseen / flat / clamp cases
  dir_row_t directed_plan [25] = '{
    // normalize before any observe: unseen dimension
    '{FUNC_NORMALIZE, 6'd0,  32'sh0000_0000, 1'b1, 17'd0,     1'b1},
    '{FUNC_NORMALIZE, 6'd63, 32'sh7FFF_FFFF, 1'b1, 17'd0,     1'b1},
    // single observation gives a flat range
    '{FUNC_OBSERVE,   6'd0,  32'sh8000_0000, 1'b0, 17'd0,     1'b0},
    '{FUNC_NORMALIZE, 6'd0,  32'sh0000_0000, 1'b1, 17'd0,     1'b1},
    // full signed range on dim 0
    '{FUNC_OBSERVE,   6'd0,  32'sh7FFF_FFFF, 1'b0, 17'd0,     1'b0},
    '{FUNC_NORMALIZE, 6'd0,  32'sh8000_0000, 1'b1, 17'd0,     1'b0},
    '{FUNC_NORMALIZE, 6'd0,  32'sh7FFF_FFFF, 1'b1, 17'h10000, 1'b0},
    '{FUNC_NORMALIZE, 6'd0,  32'sh0000_0000, 1'b0, 17'd0,     1'b0},
    '{FUNC_NORMALIZE, 6'd0,  32'shFFFF_FFFF, 1'b0, 17'd0,     1'b0},
    // all-negative data: true maximum must be tracked
    '{FUNC_OBSERVE,   6'd63, -32'sd327680,   1'b0, 17'd0,     1'b0},
    '{FUNC_OBSERVE,   6'd63, -32'sd65536,    1'b0, 17'd0,     1'b0},
    '{FUNC_OBSERVE,   6'd63, -32'sd196608,   1'b0, 17'd0,     1'b0},
    '{FUNC_NORMALIZE, 6'd63, -32'sd131072,   1'b0, 17'd0,     1'b0},
    '{FUNC_NORMALIZE, 6'd63, -32'sd393216,   1'b1, 17'd0,     1'b0},
    '{FUNC_NORMALIZE, 6'd63, 32'sh0000_0000, 1'b1, 17'h10000, 1'b0},
    // unused code is dropped
    '{FUNC_UNUSED,    6'd42, 32'sh1234_5678, 1'b0, 17'd0,     1'b0},
    // clear forgets everything, old range must not leak back
    '{FUNC_CLEAR,     6'd0,  32'sh0000_0000, 1'b0, 17'd0,     1'b0},
    '{FUNC_NORMALIZE, 6'd0,  32'sd5,         1'b1, 17'd0,     1'b1},
    '{FUNC_OBSERVE,   6'd0,  32'sd100,       1'b0, 17'd0,     1'b0},
    '{FUNC_OBSERVE,   6'd0,  32'sd300,       1'b0, 17'd0,     1'b0},
    '{FUNC_NORMALIZE, 6'd0,  32'sd200,       1'b0, 17'd0,     1'b0},
    '{FUNC_NORMALIZE, 6'd0,  32'sd299,       1'b0, 17'd0,     1'b0},
    '{FUNC_NORMALIZE, 6'd0,  32'sd101,       1'b0, 17'd0,     1'b0},
    '{FUNC_OBSERVE,   6'd21, 32'sd7,         1'b0, 17'd0,     1'b0},
    '{FUNC_NORMALIZE, 6'd21, 32'sd7,         1'b1, 17'd0,     1'b1}
  };

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $time, what);
    mismatches++;
  endtask

  // update the tracked ranges for one command; returns 1 when the block
  // owes a result, with the expected answer in scaled_out
  function automatic bit track_and_scale(input item_t cmd, output result_t scaled_out);
    int d;
    int x;
    longint num;
    longint den;
    longint q;
    d = int'(cmd.dim);
    x = cmd.sample;
    scaled_out = '0;
    case (cmd.func)
      FUNC_CLEAR: begin
        foreach (range_seen[i]) range_seen[i] = 1'b0;
        return 1'b0;
      end
      FUNC_OBSERVE: begin
        if (!range_seen[d]) begin
          // first observation sets both ends
          range_lo[d] = x;
          range_hi[d] = x;
          range_seen[d] = 1'b1;
        end else begin
          if (x < range_lo[d]) range_lo[d] = x;
          if (x > range_hi[d]) range_hi[d] = x;
        end
        return 1'b0;
      end
      FUNC_NORMALIZE: begin
        if (!range_seen[d] || range_lo[d] == range_hi[d]) begin
          scaled_out.flat = 1'b1;
        end else if (x <= range_lo[d]) begin
          scaled_out.scaled = '0;
        end else if (x >= range_hi[d]) begin
          scaled_out.scaled = ONE_Q16;
        end else begin
          // exact difference, quotient truncated toward zero
          num = (longint'(x) - longint'(range_lo[d])) <<< QBITS;
          den = longint'(range_hi[d]) - longint'(range_lo[d]);
          q = num / den;
          scaled_out.scaled = q[16:0];
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // per-item sender idle, with stretches of back-to-back transfers
  function automatic int sender_gap();
    if ($urandom_range(0, 19) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 13);
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input item_t cmd, input int gap, input bit typed,
                           input result_t typed_res);
    result_t predicted;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= cmd;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    // transfer happened at this edge
    if (track_and_scale(cmd, predicted))
      scaled_due = {scaled_due, (typed ? typed_res : predicted)};
    @(negedge clk);
  endtask

  // hold off the sender until every owed result is back and the block settles
  task automatic drain_results();
    start <= 1'b0;
    while (scaled_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // random sample for one dimension; normalize mostly lands inside the range
  function automatic logic signed [31:0] pick_sample(input int d, input bit for_scale);
    longint span;
    longint unsigned r64;
    int pick;
    if (for_scale && range_seen[d] && $urandom_range(0, 9) < 6) begin
      span = longint'(range_hi[d]) - longint'(range_lo[d]);
      r64 = {$urandom, $urandom};
      return 32'(longint'(range_lo[d]) + longint'(r64 % longint'(span + 1)));
    end
    pick = $urandom_range(0, 9);
    if (pick < 3) return $urandom;                                 // full range
    if (pick < 7) return $signed($urandom_range(0, 2097152)) - 1048576; // near 0
    if (pick < 8) begin
      // extremes of the signed field
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return 32'sh0000_0000;
        default: return 32'shFFFF_FFFF;
      endcase
    end
    // few distinct whole values, so ranges go flat now and then
    return ($signed($urandom_range(0, 4)) - 2) <<< QBITS;
  endfunction

  // result checker: done is a one-cycle strobe, no back-pressure
  always @(posedge clk) begin
    result_t owed;
    if (!rst && done) begin
      if (scaled_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result scaled=%0d flat=%0d",
                                  result.scaled, result.flat));
      end else begin
        owed = scaled_due.pop_front();
        if (result.scaled !== owed.scaled)
          report_mismatch($sformatf("scaled %0d, expected %0d", result.scaled,
                                    owed.scaled));
        if (result.flat !== owed.flat)
          report_mismatch($sformatf("flat %0d, expected %0d", result.flat,
                                    owed.flat));
      end
    end
  end

  // watchdog on cycles without any transfer in either direction
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    item_t cmd;
    int sent;
    int roll;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    foreach (directed_plan[i]) begin
      cmd.func = directed_plan[i].func;
      cmd.dim = directed_plan[i].dim;
      cmd.sample = directed_plan[i].sample;
      send_item(cmd, sender_gap(), directed_plan[i].typed,
                {directed_plan[i].scaled, directed_plan[i].flat});
    end
    drain_results();

    // random traffic: mostly observe/normalize on a handful of busy dimensions
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      cmd.dim = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 7))
                                           : 6'($urandom_range(0, DIMS - 1));
      if (roll < 2) cmd.func = FUNC_CLEAR;
      else if (roll < 5) cmd.func = FUNC_UNUSED;
      else if (roll < 52) cmd.func = FUNC_OBSERVE;
      else cmd.func = FUNC_NORMALIZE;
      cmd.sample = pick_sample(int'(cmd.dim), cmd.func == FUNC_NORMALIZE);
      send_item(cmd, sender_gap(), 1'b0, '0);
      if (cmd.func != FUNC_UNUSED) sent++;
      // occasional full stop until the block has answered everything
      if ($urandom_range(0, 99) < 2) drain_results();
    end

    drain_results();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/mmnorm_pkg.sv
hw/rtl/mmnorm_div.sv
hw/rtl/minmax_feature_normalizer.sv
dv/tb_minmax_feature_normalizer.sv
